@@ hw/rtl/decay_normalisation_estimator_top_macros.svh @@
// assertion macros for the decay normalisation estimator
// used by the top level only; no other dependencies
`ifndef DECAY_NORMALISATION_ESTIMATOR_TOP_MACROS_SVH
`define DECAY_NORMALISATION_ESTIMATOR_TOP_MACROS_SVH

// same-cycle implication
`define DNE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dne assertion failed");

// next-cycle implication
`define DNE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dne assertion failed");

`endif

@@ hw/rtl/dne_pkg.sv @@
// shared types, codes and the 2^x lookup table of the decay estimator
// no dependencies
package dne_pkg;

    localparam int EXP_BITS  = 8;
    localparam int EXP_SIZE  = (1 << EXP_BITS) + 1;
    localparam int EXP_SH    = 16 - EXP_BITS;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW   = $clog2(FIFO_DEPTH);
    localparam logic [22:0] DECAY_MUL = 23'd2820383;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_ZERO_DEN = 2'd2;

    localparam logic [1:0] REG_START  = 2'd0;
    localparam logic [1:0] REG_END    = 2'd1;
    localparam logic [1:0] REG_FRAMES = 2'd2;

    typedef struct packed {
        logic               sel;
        logic signed [16:0] t;
        logic [31:0]        cnt;
        logic               last;
    } t_item;

    typedef logic [31:0] t_tab [0:EXP_SIZE-1];

    function automatic longint unsigned isqrt64(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        longint unsigned xx;
        int i;
        r  = 64'd0;
        b  = 64'd1 << 62;
        xx = x;
        for (i = 0; i < 32; i++) begin
            if (b > xx) b = b >> 2;
        end
        for (i = 0; i < 32; i++) begin
            if (b != 64'd0) begin
                if (xx >= r + b) begin
                    xx = xx - (r + b);
                    r  = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // 2^(k/2^EXP_BITS) in Q30 from repeated square roots of two
    function automatic t_tab build_pow2();
        longint unsigned root [0:EXP_BITS];
        longint unsigned v;
        t_tab tab;
        int j;
        int k;
        root[0] = 64'd1 << 31;
        for (j = 1; j <= EXP_BITS; j++) root[j] = isqrt64(root[j-1] << 30);
        for (k = 0; k < EXP_SIZE - 1; k++) begin
            v = 64'd1 << 30;
            for (j = 0; j < EXP_BITS; j++) begin
                if (((k >> j) & 1) != 0) v = (v * root[EXP_BITS-j] + (64'd1 << 29)) >> 30;
            end
            tab[k] = v[31:0];
        end
        tab[EXP_SIZE-1] = 32'h8000_0000;
        return tab;
    endfunction

    localparam t_tab POW2_TAB = build_pow2();

endpackage

@@ hw/rtl/decay_normalisation_estimator_top.sv @@
// top level of the decay normalisation estimator: config registers, front and back
// depends on dne_pkg, dne_front, dne_back and the macros header
//
// Usage:
//  edges enter through a queue port: push with edge_time, bin_count and last_edge,
//  accepted when push is high and full is low. A four-entry queue holds edges while
//  the back end works, so the source can run ahead.
//  One result per edge marked last_edge: norm_const (Q32.16) and status, read through
//  empty/pop. The result sits in an output register; the next histogram's edges are
//  still accepted while it waits.
//  Each edge occupies the back end through its multiply, table interpolation, scale and
//  accumulate steps. A final edge then goes straight to the result when the range is
//  empty or the denominator is zero, after the multiply and check when the quotient
//  saturates, and otherwise through the bit-serial 48-step divider.
//  Config (start_time, end_time, good_frames) is written through cfg_we/idx/data
//  while the block is idle; unknown indexes are ignored.
//  Reset (synchronous, active low) restores register defaults, empties the queue,
//  clears the accumulators and the result register's valid flag.
//  If the receiver stalls, the back end holds a finished result until the output
//  register frees, and the queue fills and raises full.
`include "decay_normalisation_estimator_top_macros.svh"

module decay_normalisation_estimator_top import dne_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [16:0] i_edge_time,
    input  logic [31:0] i_bin_count,
    input  logic        i_last_edge,
    output logic        empty,
    input  logic        pop,
    output logic [47:0] o_norm_const,
    output logic [1:0]  o_status,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    logic signed [16:0] r_start_time;
    logic signed [16:0] r_end_time;
    logic [31:0]        r_good_frames;
    logic               w_valid;
    logic               w_take;
    t_item              w_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_time  <= 17'sd0;
            r_end_time    <= 17'sd32768;
            r_good_frames <= 32'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_START:  r_start_time  <= $signed(i_cfg_data[16:0]);
                REG_END:    r_end_time    <= $signed(i_cfg_data[16:0]);
                REG_FRAMES: r_good_frames <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    dne_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .i_edge_time  ($signed(i_edge_time)),
        .i_bin_count  (i_bin_count),
        .i_last_edge  (i_last_edge),
        .i_start_time (r_start_time),
        .i_end_time   (r_end_time),
        .full         (full),
        .o_valid      (w_valid),
        .o_item       (w_item),
        .i_take       (w_take)
    );

    dne_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_valid),
        .i_item        (w_item),
        .o_take        (w_take),
        .i_good_frames (r_good_frames),
        .empty         (empty),
        .pop           (pop),
        .o_norm_const  (o_norm_const),
        .o_status      (o_status)
    );

    // an error status always comes with a zero constant
    `DNE_ASSERT_IMPL(a_status_zero_norm, i_clk, i_rst_n, !empty && o_status != ST_OK, o_norm_const == 48'd0)
    // reset leaves no result and an open input queue
    `DNE_ASSERT_NEXT(a_reset_clear, i_clk, 1'b1, !i_rst_n, empty && !full)

endmodule

@@ hw/rtl/dne_front.sv @@
// front end: takes edges, tags them as inside or outside the window, queues them
// depends on dne_pkg
module dne_front import dne_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  logic signed [16:0] i_edge_time,
    input  logic [31:0]        i_bin_count,
    input  logic               i_last_edge,
    input  logic signed [16:0] i_start_time,
    input  logic signed [16:0] i_end_time,
    output logic               full,
    output logic               o_valid,
    output t_item              o_item,
    input  logic               i_take
);

    t_item                r_mem [0:FIFO_DEPTH-1];
    logic [FIFO_AW-1:0]   r_wr;
    logic [FIFO_AW-1:0]   r_rd;
    logic [FIFO_AW:0]     r_cnt;
    logic                 w_push;
    logic                 w_pop;
    t_item                w_item;

    assign full    = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign w_push  = push && !full;
    assign w_pop   = i_take && o_valid;

    always_comb begin
        w_item.sel  = (i_edge_time > i_start_time) && (i_edge_time <= i_end_time);
        w_item.t    = i_edge_time;
        w_item.cnt  = i_bin_count;
        w_item.last = i_last_edge;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= w_item;
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ hw/rtl/dne_back.sv @@
// back end: decay value, accumulation, final division and result register
// depends on dne_pkg
module dne_back import dne_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_take,
    input  logic [31:0] i_good_frames,
    output logic        empty,
    input  logic        pop,
    output logic [47:0] o_norm_const,
    output logic [1:0]  o_status
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_EXP, S_ACC, S_DEN, S_MLO, S_MHI, S_DCHK, S_DIV, S_DONE
    } t_state;

    localparam logic [47:0] MAX48 = '1;
    localparam logic [31:0] MAX32 = '1;

    t_state              r_state;
    t_item               r_it;
    logic [24:0]         r_rb;
    logic [31:0]         r_v;
    logic signed [10:0]  r_s;
    logic [47:0]         r_count_total;
    logic [47:0]         r_decay_total;
    logic [31:0]         r_first_decay;
    logic [31:0]         r_latest_decay;
    logic [31:0]         r_latest_count;
    logic                r_seen;
    logic [49:0]         r_den;
    logic [47:0]         r_num;
    logic [81:0]         r_d;
    logic [82:0]         r_rem;
    logic [47:0]         r_nlo;
    logic [47:0]         r_q;
    logic [5:0]          r_bit;
    logic [47:0]         r_res_norm;
    logic [1:0]          r_res_status;
    logic                r_out_valid;
    logic [47:0]         r_out_norm;
    logic [1:0]          r_out_status;

    logic signed [39:0]  w_prod;
    logic signed [41:0]  w_x;
    logic [EXP_BITS-1:0] w_idx;
    logic [EXP_BITS:0]   w_idx_hi;
    logic [EXP_SH-1:0]   w_frac;
    logic [31:0]         w_lo;
    logic [31:0]         w_hi;
    logic [31:0]         w_diff;
    logic [31+EXP_SH:0]  w_dprod;
    logic [31:0]         w_v;
    logic [31:0]         w_e;
    logic [32:0]         w_up;
    logic [10:0]         w_ns;
    logic [63:0]         w_dn;
    logic [48:0]         w_csum;
    logic [48:0]         w_dsum;
    logic signed [50:0]  w_den2;
    logic [56:0]         w_pp;
    logic [82:0]         w_trial;
    logic                w_ge;
    logic [82:0]         w_top;

    assign empty        = !r_out_valid;
    assign o_norm_const = r_out_norm;
    assign o_status     = r_out_status;
    assign o_take       = (r_state == S_IDLE) && i_valid;

    // p = -t*M, rounded to Q16 with a positive bias
    always_comb begin
        w_prod = r_it.t * $signed({1'b0, DECAY_MUL});
        w_x    = 42'sd1099511660544 - 42'(w_prod);
    end

    // table lookup and linear interpolation
    always_comb begin
        w_idx    = r_rb[15:EXP_SH];
        w_idx_hi = {1'b0, w_idx} + 1'b1;
        w_frac   = r_rb[EXP_SH-1:0];
        w_lo     = POW2_TAB[w_idx];
        w_hi     = POW2_TAB[w_idx_hi];
        w_diff   = (w_hi >= w_lo) ? (w_hi - w_lo) : (w_lo - w_hi);
        w_dprod  = w_diff * w_frac;
        w_v      = (w_hi >= w_lo) ? (w_lo + w_dprod[31+EXP_SH:EXP_SH])
                                  : (w_lo - w_dprod[31+EXP_SH:EXP_SH]);
    end

    // scale to Q8.24 with round half up and saturation
    always_comb begin
        w_up = '0;
        w_dn = '0;
        w_ns = 11'(-r_s);
        if (r_s >= 11'sd2) begin
            w_e = MAX32;
        end else if (r_s >= 11'sd0) begin
            w_up = {1'b0, r_v} << r_s[0];
            w_e  = w_up[32] ? MAX32 : w_up[31:0];
        end else if (w_ns >= 11'd34) begin
            w_e = '0;
        end else begin
            w_dn = ({32'd0, r_v} + (64'd1 << (w_ns - 11'd1))) >> w_ns;
            w_e  = w_dn[32] ? MAX32 : w_dn[31:0];
        end
    end

    always_comb begin
        w_csum  = {1'b0, r_count_total} + {17'd0, r_latest_count};
        w_dsum  = {1'b0, r_decay_total} + {17'd0, r_latest_decay};
        w_den2  = $signed({2'b0, r_decay_total, 1'b0}) - $signed({19'd0, r_first_decay})
                - $signed({19'd0, r_latest_decay});
        w_pp    = (r_state == S_MLO) ? (r_den[24:0] * i_good_frames)
                                     : (r_den[49:25] * i_good_frames);
        w_top   = {42'd0, r_num[47:7]};
        w_trial = {r_rem[81:0], r_nlo[47]};
        w_ge    = (w_trial >= {1'b0, r_d});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count_total  <= '0;
            r_decay_total  <= '0;
            r_first_decay  <= '0;
            r_latest_decay <= '0;
            r_latest_count <= '0;
            r_seen         <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (pop && r_out_valid && r_state != S_DONE) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_it    <= i_item;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_rb    <= w_x[40:16];
                    r_state <= S_EXP;
                end
                S_EXP: begin
                    r_v     <= w_v;
                    r_s     <= $signed({2'b0, r_rb[24:16]}) - 11'sd262;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_it.sel) begin
                        if (r_seen) begin
                            r_count_total <= w_csum[48] ? MAX48 : w_csum[47:0];
                            r_decay_total <= w_dsum[48] ? MAX48 : w_dsum[47:0];
                        end else begin
                            r_first_decay <= w_e;
                            r_seen        <= 1'b1;
                        end
                        r_latest_decay <= w_e;
                        r_latest_count <= r_it.cnt;
                    end
                    r_state <= r_it.last ? S_DEN : S_IDLE;
                end
                S_DEN: begin
                    r_den <= w_den2[49:0];
                    r_num <= r_count_total;
                    if (!r_seen) begin
                        r_res_norm   <= '0;
                        r_res_status <= ST_EMPTY;
                        r_state      <= S_DONE;
                    end else if (w_den2 <= 51'sd0 || i_good_frames == '0) begin
                        r_res_norm   <= '0;
                        r_res_status <= ST_ZERO_DEN;
                        r_state      <= S_DONE;
                    end else begin
                        r_state <= S_MLO;
                    end
                    r_count_total  <= '0;
                    r_decay_total  <= '0;
                    r_first_decay  <= '0;
                    r_latest_decay <= '0;
                    r_latest_count <= '0;
                    r_seen         <= 1'b0;
                end
                S_MLO: begin
                    r_d     <= {25'd0, w_pp};
                    r_state <= S_MHI;
                end
                S_MHI: begin
                    r_d     <= r_d + {w_pp, 25'd0};
                    r_state <= S_DCHK;
                end
                S_DCHK: begin
                    // quotient would not fit in 48 bits
                    if (w_top >= {1'b0, r_d}) begin
                        r_res_norm   <= MAX48;
                        r_res_status <= ST_OK;
                        r_state      <= S_DONE;
                    end else begin
                        r_rem   <= w_top;
                        r_nlo   <= {r_num[6:0], 41'd0};
                        r_q     <= '0;
                        r_bit   <= 6'd47;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= w_ge ? (w_trial - {1'b0, r_d}) : w_trial;
                    r_q   <= {r_q[46:0], w_ge};
                    r_nlo <= {r_nlo[46:0], 1'b0};
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == '0) begin
                        r_res_norm   <= {r_q[46:0], w_ge};
                        r_res_status <= ST_OK;
                        r_state      <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || pop) begin
                        r_out_valid  <= 1'b1;
                        r_out_norm   <= r_res_norm;
                        r_out_status <= r_res_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
